// ----- hdl/adk_pkg.sv -----
// adk_pkg: shared types and constants of the analog keypad debouncer
// no dependencies

package adk_pkg;

	localparam int SampleW = 10;
	localparam int TimeW   = 32;
	localparam int DebW    = 16;
	localparam int CfgW    = 16;
	localparam int CfgIdxW = 3;

	typedef enum logic [1:0] {
		KEY_A    = 2'd0,
		KEY_B    = 2'd1,
		KEY_C    = 2'd2,
		KEY_NONE = 2'd3
	} key_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_A_UPPER = 3'd0,
		REG_KEY_B_LOWER = 3'd1,
		REG_KEY_B_UPPER = 3'd2,
		REG_KEY_C_LOWER = 3'd3,
		REG_KEY_C_UPPER = 3'd4,
		REG_DEBOUNCE_MS = 3'd5
	} cfg_reg_t;

	localparam logic [SampleW-1:0] KeyAUpperRst = 10'd50;
	localparam logic [SampleW-1:0] KeyBLowerRst = 10'd470;
	localparam logic [SampleW-1:0] KeyBUpperRst = 10'd550;
	localparam logic [SampleW-1:0] KeyCLowerRst = 10'd640;
	localparam logic [SampleW-1:0] KeyCUpperRst = 10'd720;
	localparam logic [DebW-1:0]    DebounceRst  = 16'd50;

	typedef struct packed {
		logic [SampleW-1:0] a_upper;
		logic [SampleW-1:0] b_lower;
		logic [SampleW-1:0] b_upper;
		logic [SampleW-1:0] c_lower;
		logic [SampleW-1:0] c_upper;
	} windows_t;

	typedef struct packed {
		logic  released;
		logic  clicked;
		key_t  previous_key;
		key_t  current_key;
	} result_t;

endpackage

// ----- hdl/adk_classify.sv -----
// adk_classify: window compares that map one sample to a key code
// depends on adk_pkg

module adk_classify (
	input  logic [adk_pkg::SampleW-1:0] sample,
	input  adk_pkg::windows_t           win,
	output adk_pkg::key_t               key
);

	always_comb begin
		if (sample < win.a_upper) begin
			key = adk_pkg::KEY_A;
		end else if (sample > win.b_lower && sample < win.b_upper) begin
			key = adk_pkg::KEY_B;
		end else if (sample > win.c_lower && sample < win.c_upper) begin
			key = adk_pkg::KEY_C;
		end else begin
			key = adk_pkg::KEY_NONE;
		end
	end

endmodule

// ----- hdl/adk_debounce.sv -----
// adk_debounce: debounce state and result register
// depends on adk_pkg

module adk_debounce (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  adk_pkg::key_t              key_s1,
	input  logic [adk_pkg::TimeW-1:0]  time_s1,
	input  logic [adk_pkg::DebW-1:0]   debounce_ms,
	output adk_pkg::result_t           result_q
);

	adk_pkg::key_t             raw_q;
	adk_pkg::key_t             stable_q;
	adk_pkg::key_t             prior_q;
	logic [adk_pkg::TimeW-1:0] change_q;
	logic [adk_pkg::TimeW-1:0] elapsed;
	logic                      accept;

	assign elapsed = time_s1 - change_q;
	assign accept  = (key_s1 == raw_q) && (raw_q != stable_q) &&
		(elapsed >= {{(adk_pkg::TimeW-adk_pkg::DebW){1'b0}}, debounce_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= adk_pkg::KEY_NONE;
			stable_q <= adk_pkg::KEY_NONE;
			prior_q  <= adk_pkg::KEY_NONE;
			change_q <= '0;
		end else if (advance) begin
			if (key_s1 != raw_q) begin
				raw_q    <= key_s1;
				change_q <= time_s1;
			end else if (accept) begin
				prior_q  <= stable_q;
				stable_q <= raw_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.current_key  <= accept ? raw_q : stable_q;
			result_q.previous_key <= accept ? stable_q : prior_q;
			result_q.clicked      <= accept && (stable_q == adk_pkg::KEY_NONE);
			result_q.released     <= accept && (raw_q == adk_pkg::KEY_NONE);
		end
	end

`ifndef SYNTHESIS
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) |-> !(result_q.clicked && result_q.released))
		else $error("click and release together");
	a_click_keys: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) && result_q.clicked |->
		result_q.previous_key == adk_pkg::KEY_NONE &&
		result_q.current_key != adk_pkg::KEY_NONE)
		else $error("click without none-to-key change");
	a_release_keys: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) && result_q.released |->
		result_q.current_key == adk_pkg::KEY_NONE &&
		result_q.previous_key != adk_pkg::KEY_NONE)
		else $error("release without key-to-none change");
	a_accept_raw: assert property (@(posedge clk) disable iff (!arst_n)
		advance && accept |=> stable_q == raw_q)
		else $error("accepted key differs from raw key");
`endif

endmodule

// ----- hdl/analog_keypad_debouncer.sv -----
// analog_keypad_debouncer: top level, input register, config registers
// depends on adk_pkg, adk_classify, adk_debounce
//
// Usage: one word on the s_ side carries an ADC sample of a resistor-ladder
// keypad and a millisecond timestamp; each accepted word gives exactly one
// result word on the m_ side with the debounced current key, the key before
// the last accepted change, and click and release flags.
// Key code: 0 A, 1 B, 2 C, 3 none.
// Path: an accepted word passes the input register, then the result register,
// which raises m_tvalid. Throughput: one word per cycle while m_tready is not held low;
// the window compares sit before the input register, the 32-bit time subtract between them.
// Stall: when m_tready is low the result holds, the input register keeps one
// more word, and s_tready falls only when both are full.
// Reset: arst_n clears both valid flags, sets raw, current and previous key to
// none, the change time to zero, and the config registers to their defaults.
// Config: write cfg_data to register cfg_index while cfg_we is high, only when
// the block is idle; indexes beyond the list are ignored.

module analog_keypad_debouncer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [47:0]                  s_tdata,  // adc_sample[9:0], time_ms[41:10]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,  // current_key, previous_key, clicked, released
	input  logic                         cfg_we,
	input  logic [adk_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [adk_pkg::CfgW-1:0]     cfg_data
);

	adk_pkg::windows_t           win_q;
	logic [adk_pkg::DebW-1:0]    debounce_q;
	adk_pkg::key_t               key_in;
	adk_pkg::key_t               key_s1;
	logic [adk_pkg::TimeW-1:0]   time_s1;
	logic                        valid_s1;
	logic                        advance;
	adk_pkg::result_t            result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.a_upper <= adk_pkg::KeyAUpperRst;
			win_q.b_lower <= adk_pkg::KeyBLowerRst;
			win_q.b_upper <= adk_pkg::KeyBUpperRst;
			win_q.c_lower <= adk_pkg::KeyCLowerRst;
			win_q.c_upper <= adk_pkg::KeyCUpperRst;
			debounce_q    <= adk_pkg::DebounceRst;
		end else if (cfg_we) begin
			case (adk_pkg::cfg_reg_t'(cfg_index))
				adk_pkg::REG_KEY_A_UPPER: win_q.a_upper <= cfg_data[adk_pkg::SampleW-1:0];
				adk_pkg::REG_KEY_B_LOWER: win_q.b_lower <= cfg_data[adk_pkg::SampleW-1:0];
				adk_pkg::REG_KEY_B_UPPER: win_q.b_upper <= cfg_data[adk_pkg::SampleW-1:0];
				adk_pkg::REG_KEY_C_LOWER: win_q.c_lower <= cfg_data[adk_pkg::SampleW-1:0];
				adk_pkg::REG_KEY_C_UPPER: win_q.c_upper <= cfg_data[adk_pkg::SampleW-1:0];
				adk_pkg::REG_DEBOUNCE_MS: debounce_q    <= cfg_data[adk_pkg::DebW-1:0];
				default: ;
			endcase
		end
	end

	adk_classify u_classify (
		.sample (s_tdata[9:0]),
		.win    (win_q),
		.key    (key_in)
	);

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1  <= key_in;
			time_s1 <= s_tdata[41:10];
		end
	end

	adk_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.key_s1      (key_s1),
		.time_s1     (time_s1),
		.debounce_ms (debounce_q),
		.result_q    (result_q)
	);

	assign m_tdata = {2'b00, result_q};

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for analog_keypad_debouncer
// drives sample/time words and checks each result word against an in-bench key tracker
// depends on adk_pkg and the analog_keypad_debouncer rtl
`timescale 1ns / 100ps

module tb_top;

	localparam int StallLimit = 5000;
	localparam int HoldCycles = 80;
	localparam int PhaseWords = 150;
	localparam logic [adk_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct packed {
		logic [adk_pkg::TimeW-1:0]   ms;
		logic [adk_pkg::SampleW-1:0] sample;
	} sample_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [adk_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [adk_pkg::CfgW-1:0] cfg_data = '0;

	sample_word_t pend_q[$];
	adk_pkg::result_t key_exp_q[$];

	adk_pkg::windows_t win = '{a_upper: adk_pkg::KeyAUpperRst,
		b_lower: adk_pkg::KeyBLowerRst, b_upper: adk_pkg::KeyBUpperRst,
		c_lower: adk_pkg::KeyCLowerRst, c_upper: adk_pkg::KeyCUpperRst};
	logic [adk_pkg::DebW-1:0] dbnc = adk_pkg::DebounceRst;
	adk_pkg::key_t trk_raw = adk_pkg::KEY_NONE;
	adk_pkg::key_t trk_stable = adk_pkg::KEY_NONE;
	adk_pkg::key_t trk_prior = adk_pkg::KEY_NONE;
	logic [adk_pkg::TimeW-1:0] trk_since = '0;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;
	int err_cnt = 0;
	int wd_cnt = 0;
	logic [adk_pkg::TimeW-1:0] gen_time;
	sample_word_t drv_w, acc_w;
	adk_pkg::result_t want, got;

	analog_keypad_debouncer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic adk_pkg::key_t classify_sample(input logic [adk_pkg::SampleW-1:0] s);
		if (s < win.a_upper)
			return adk_pkg::KEY_A;
		if (s > win.b_lower && s < win.b_upper)
			return adk_pkg::KEY_B;
		if (s > win.c_lower && s < win.c_upper)
			return adk_pkg::KEY_C;
		return adk_pkg::KEY_NONE;
	endfunction

	function automatic adk_pkg::result_t track_keys(input logic [adk_pkg::SampleW-1:0] s,
		input logic [adk_pkg::TimeW-1:0] t);
		adk_pkg::key_t cls;
		logic [adk_pkg::TimeW-1:0] dt;
		adk_pkg::result_t r;
		cls = classify_sample(s);
		r.clicked = 1'b0;
		r.released = 1'b0;
		if (cls != trk_raw) begin
			trk_raw = cls;
			trk_since = t;
		end else begin
			dt = t - trk_since;
			if (dt >= {16'b0, dbnc} && trk_raw != trk_stable) begin
				r.clicked = (trk_stable == adk_pkg::KEY_NONE);
				r.released = (trk_raw == adk_pkg::KEY_NONE);
				trk_prior = trk_stable;
				trk_stable = trk_raw;
			end
		end
		r.current_key = trk_stable;
		r.previous_key = trk_prior;
		return r;
	endfunction

	function automatic logic [adk_pkg::SampleW-1:0] pick_sample(input adk_pkg::key_t k);
		logic [adk_pkg::SampleW-1:0] s;
		int n;
		s = adk_pkg::SampleW'($urandom());
		case (k)
			adk_pkg::KEY_A: begin
				if (win.a_upper != 0)
					s = adk_pkg::SampleW'($urandom_range(0, win.a_upper - 1));
			end
			adk_pkg::KEY_B: begin
				if (win.b_upper > win.b_lower + 1)
					s = adk_pkg::SampleW'($urandom_range(win.b_lower + 1, win.b_upper - 1));
			end
			adk_pkg::KEY_C: begin
				if (win.c_upper > win.c_lower + 1)
					s = adk_pkg::SampleW'($urandom_range(win.c_lower + 1, win.c_upper - 1));
			end
			default: begin
				for (n = 0; n < 8 && classify_sample(s) != adk_pkg::KEY_NONE; n++)
					s = adk_pkg::SampleW'($urandom());
			end
		endcase
		return s;
	endfunction

	task automatic push_word(input logic [adk_pkg::SampleW-1:0] s,
		input logic [adk_pkg::TimeW-1:0] t);
		sample_word_t w;
		w.sample = s;
		w.ms = t;
		pend_q.push_back(w);
	endtask

	// mostly held key presses with bounce, plus time jumps and noise
	task automatic gen_presses(input int n);
		int cnt;
		int r;
		int hold;
		int unsigned step;
		adk_pkg::key_t k;
		cnt = 0;
		step = dbnc / 3 + 1;
		while (cnt < n) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				k = adk_pkg::key_t'($urandom_range(0, 3));
				hold = $urandom_range(1, 10);
				repeat (hold) begin
					if ($urandom_range(0, 9) == 0)
						push_word(adk_pkg::SampleW'($urandom()), gen_time);
					else
						push_word(pick_sample(k), gen_time);
					gen_time = gen_time + $urandom_range(0, step);
					cnt++;
				end
			end else if (r < 90) begin
				gen_time = $urandom();
				push_word(adk_pkg::SampleW'($urandom()), gen_time);
				cnt++;
			end else begin
				push_word(adk_pkg::SampleW'($urandom()), gen_time);
				gen_time = gen_time + $urandom_range(0, 3);
				cnt++;
			end
		end
	endtask

	task automatic write_reg(input logic [adk_pkg::CfgIdxW-1:0] idx,
		input logic [adk_pkg::CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			adk_pkg::REG_KEY_A_UPPER: win.a_upper = val[adk_pkg::SampleW-1:0];
			adk_pkg::REG_KEY_B_LOWER: win.b_lower = val[adk_pkg::SampleW-1:0];
			adk_pkg::REG_KEY_B_UPPER: win.b_upper = val[adk_pkg::SampleW-1:0];
			adk_pkg::REG_KEY_C_LOWER: win.c_lower = val[adk_pkg::SampleW-1:0];
			adk_pkg::REG_KEY_C_UPPER: win.c_upper = val[adk_pkg::SampleW-1:0];
			adk_pkg::REG_DEBOUNCE_MS: dbnc = val[adk_pkg::DebW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// upper bits carry junk that the block must drop
	task automatic write_win(input logic [adk_pkg::CfgIdxW-1:0] idx, input int unsigned v);
		logic [adk_pkg::CfgW-1:0] junk;
		junk = $urandom();
		write_reg(idx, {junk[adk_pkg::CfgW-1:adk_pkg::SampleW],
			adk_pkg::SampleW'(v > 1023 ? 1023 : v)});
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || s_tvalid || key_exp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_phase(input int p);
		int unsigned lo;
		case (p)
			1: begin
				write_reg(adk_pkg::REG_DEBOUNCE_MS, 16'd0);
				write_reg(RegUnused, adk_pkg::CfgW'($urandom()));
			end
			2: begin
				lo = $urandom_range(200, 500);
				write_win(adk_pkg::REG_KEY_A_UPPER, $urandom_range(0, 200));
				write_win(adk_pkg::REG_KEY_B_LOWER, lo);
				lo = lo + $urandom_range(2, 150);
				write_win(adk_pkg::REG_KEY_B_UPPER, lo);
				lo = lo + $urandom_range(0, 100);
				write_win(adk_pkg::REG_KEY_C_LOWER, lo);
				write_win(adk_pkg::REG_KEY_C_UPPER, lo + $urandom_range(2, 200));
				write_reg(adk_pkg::REG_DEBOUNCE_MS, adk_pkg::CfgW'($urandom_range(1, 300)));
			end
			3: begin
				write_win(adk_pkg::REG_KEY_A_UPPER, 600);
				write_win(adk_pkg::REG_KEY_B_LOWER, 0);
				write_win(adk_pkg::REG_KEY_B_UPPER, 1023);
				write_win(adk_pkg::REG_KEY_C_LOWER, 0);
				write_win(adk_pkg::REG_KEY_C_UPPER, 1023);
				write_reg(adk_pkg::REG_DEBOUNCE_MS, 16'hffff);
			end
			4: begin
				lo = $urandom_range(600, 700);
				write_win(adk_pkg::REG_KEY_A_UPPER, $urandom_range(1, 100));
				write_win(adk_pkg::REG_KEY_B_LOWER, 700);
				write_win(adk_pkg::REG_KEY_B_UPPER, 300);
				write_win(adk_pkg::REG_KEY_C_LOWER, lo);
				write_win(adk_pkg::REG_KEY_C_UPPER, lo + $urandom_range(2, 100));
				write_reg(adk_pkg::REG_DEBOUNCE_MS, 16'd1);
			end
			5: begin
				write_win(adk_pkg::REG_KEY_A_UPPER, 1023);
				write_win(adk_pkg::REG_KEY_B_LOWER, 1022);
				write_win(adk_pkg::REG_KEY_B_UPPER, 1023);
				write_win(adk_pkg::REG_KEY_C_LOWER, 0);
				write_win(adk_pkg::REG_KEY_C_UPPER, 1);
				write_reg(adk_pkg::REG_DEBOUNCE_MS, adk_pkg::CfgW'($urandom_range(0, 65535)));
			end
			default: ;
		endcase
		cfg_we <= 1'b0;
		case (p)
			2: begin snd_idle_pct <= 74; rcv_stall_pct <= 0; end
			3: begin snd_idle_pct <= 0; rcv_stall_pct <= 74; end
			4: begin snd_idle_pct <= 16; rcv_stall_pct <= 16; end
			default: begin snd_idle_pct <= 0; rcv_stall_pct <= 0; end
		endcase
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				acc_w = sample_word_t'(s_tdata[41:0]);
				key_exp_q.push_back(track_keys(acc_w.sample, acc_w.ms));
			end
			if (!s_tvalid || s_tready) begin
				if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					drv_w = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, drv_w};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (key_exp_q.size() == 0) begin
					$error("result word with none expected, m_tdata %h", m_tdata);
					err_cnt++;
				end else begin
					want = key_exp_q.pop_front();
					got = adk_pkg::result_t'(m_tdata[5:0]);
					if (got.current_key !== want.current_key) begin
						$error("current_key expected %0d got %0d", want.current_key,
							got.current_key);
						err_cnt++;
					end
					if (got.previous_key !== want.previous_key) begin
						$error("previous_key expected %0d got %0d", want.previous_key,
							got.previous_key);
						err_cnt++;
					end
					if (got.clicked !== want.clicked) begin
						$error("clicked expected %0d got %0d", want.clicked, got.clicked);
						err_cnt++;
					end
					if (got.released !== want.released) begin
						$error("released expected %0d got %0d", want.released, got.released);
						err_cnt++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_cnt <= HoldCycles;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			wd_cnt <= 0;
		end else if (wd_cnt >= StallLimit) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			wd_cnt <= wd_cnt + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// long receiver hold-off while words keep coming
		hold_req <= 1'b1;
		// window edges, extremes, key-to-key change, time wrap and time going back
		push_word(10'd0, 32'd0);
		push_word(10'd49, 32'd10);
		push_word(10'd30, 32'd60);
		push_word(10'd50, 32'd61);
		push_word(10'd1023, 32'd200);
		push_word(10'd471, 32'd201);
		push_word(10'd549, 32'd300);
		push_word(10'd470, 32'd301);
		push_word(10'd550, 32'd302);
		push_word(10'd641, 32'd303);
		push_word(10'd719, 32'd400);
		push_word(10'd640, 32'd401);
		push_word(10'd720, 32'd402);
		push_word(10'd1023, 32'hffff_ffff);
		push_word(10'd1023, 32'd49);
		push_word(10'd10, 32'd100);
		push_word(10'd10, 32'd90);
		gen_time = 32'hffff_f000;
		gen_presses(PhaseWords);
		wait_idle();

		for (int p = 1; p < 6; p++) begin
			set_phase(p);
			if (p == 1) begin
				// zero debounce: accepted on the step after the change
				push_word(10'd10, 32'd1000);
				push_word(10'd10, 32'd1000);
				push_word(10'd1023, 32'd1000);
				push_word(10'd1023, 32'd1000);
			end
			gen_time = $urandom();
			gen_presses(PhaseWords);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0 && key_exp_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
